[hw/rtl/isqrt_pkg.sv]
// Shared types and constants for the integer square root core.
// Depends on nothing; used by isqrt_cell and integer_square_root_core.
`timescale 1ns / 1ps

package isqrt_pkg;

	localparam int RADICAND_WIDTH = 64;
	localparam int ROOT_WIDTH     = 32;

	// Root bits settled by the chain, one per cell.
	localparam int RT_W      = (RADICAND_WIDTH + 1) / 2;
	localparam int EXT_W     = 2 * RT_W;
	localparam int NUM_CELLS = RT_W;

	typedef logic [EXT_W-1:0]      ext_t;
	typedef logic [ROOT_WIDTH-1:0] root_t;

	// Weight of the root bit under trial: starts at the top even position.
	localparam ext_t INIT_MARK = ext_t'(1) << (EXT_W - 2);

	typedef struct packed {
		ext_t rem;   // partial remainder
		ext_t res;   // partial root, scaled
		ext_t mark;  // weight of the bit under trial
	} cell_data_t;

endpackage

[hw/rtl/integer_square_root_core.sv]
// Top level of the integer square root core: a chain of isqrt_cell stages.
// Depends on isqrt_pkg and isqrt_cell.
`timescale 1ns / 1ps
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------
//   in       | to core   | in_valid / in_ready  | radicand[63:0] unsigned
//   out      | from core | out_valid / out_ready| root[31:0] unsigned
//
// Each of the 32 cells of the chain settles one root bit.
// A new request enters every cycle unless the chain is held; the chain holds up to 32 requests at once.
// The last cell's register is the output register.
// When a finished root is not taken, the whole chain holds and in_ready drops.
// Reset clears only the valid flags of the cells.

module integer_square_root_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [63:0]              radicand,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [31:0]              root
);

	logic                  vld   [isqrt_pkg::NUM_CELLS+1];
	isqrt_pkg::cell_data_t chain [isqrt_pkg::NUM_CELLS+1];
	logic                  adv;

	// advance whenever the last cell is empty or being drained
	assign adv = !vld[isqrt_pkg::NUM_CELLS] || out_ready;

	assign vld[0]        = in_valid;
	assign chain[0].rem  = isqrt_pkg::ext_t'(radicand[isqrt_pkg::RADICAND_WIDTH-1:0]);
	assign chain[0].res  = '0;
	assign chain[0].mark = isqrt_pkg::INIT_MARK;

	for (genvar g = 0; g < isqrt_pkg::NUM_CELLS; g++) begin : g_cell
		isqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_vld   (vld[g]),
			.in_data  (chain[g]),
			.out_vld  (vld[g+1]),
			.out_data (chain[g+1])
		);
	end

	assign in_ready  = adv;
	assign out_valid = vld[isqrt_pkg::NUM_CELLS];
	assign root      =
		isqrt_pkg::root_t'(chain[isqrt_pkg::NUM_CELLS].res[isqrt_pkg::RT_W-1:0]);

	// a stalled result blocks new requests
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("request accepted while result stalled");

	// an accepted request reaches the first cell
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld[1])
		else $error("accepted request lost at first cell");

	// every bit weight has been used up at the end of the chain
	a_mark_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (chain[isqrt_pkg::NUM_CELLS].mark == '0))
		else $error("root not fully settled");

	// floor property: remainder never exceeds twice the root
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, chain[isqrt_pkg::NUM_CELLS].rem}
			<= {chain[isqrt_pkg::NUM_CELLS].res, 1'b0}))
		else $error("remainder too large for floor root");

endmodule

[hw/rtl/isqrt_cell.sv]
// One restoring square root cell: settles one root bit and hands the
// updated remainder, root and bit weight to the next cell. Uses isqrt_pkg.
`timescale 1ns / 1ps

module isqrt_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_vld,
	input  isqrt_pkg::cell_data_t in_data,
	output logic                  out_vld,
	output isqrt_pkg::cell_data_t out_data
);

	isqrt_pkg::ext_t       trial;
	logic                  take;
	isqrt_pkg::cell_data_t nxt;
	logic                  vld_q;
	isqrt_pkg::cell_data_t data_q;

	always_comb begin
		trial    = in_data.res + in_data.mark;
		take     = (in_data.rem >= trial);
		nxt.rem  = take ? (in_data.rem - trial) : in_data.rem;
		nxt.res  = (in_data.res >> 1) + (take ? in_data.mark : '0);
		nxt.mark = in_data.mark >> 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nxt;
		end
	end

	assign out_vld  = vld_q;
	assign out_data = data_q;

endmodule
